// File: rtl/hstrip_pkg.sv
// ----------------------------------------------------------------------------
// hstrip_pkg: shared types and codes for the hunk symbol stripper
// Item structs, hunk and external-entry codes, parse phases, status codes.
// ----------------------------------------------------------------------------
package hstrip_pkg;

  // Input item: one file longword or the end-of-file marker
  typedef struct packed {
    logic [31:0] word;
    logic        end_of_file;
  } in_item_t;

  // Result item: echoed word, keep flag and status
  typedef struct packed {
    logic [31:0] out_word;
    logic        keep;
    logic [2:0]  status;
  } out_item_t;

  // Parser control state passed between the top level and the step logic
  typedef struct packed {
    logic [4:0] phase;
    logic       seen;
    logic [2:0] err;
  } ctl_t;

  // Hunk type words
  localparam logic [31:0] H_UNIT    = 32'h0000_03E7;
  localparam logic [31:0] H_NAME    = 32'h0000_03E8;
  localparam logic [31:0] H_CODE    = 32'h0000_03E9;
  localparam logic [31:0] H_DATA    = 32'h0000_03EA;
  localparam logic [31:0] H_BSS     = 32'h0000_03EB;
  localparam logic [31:0] H_REL32   = 32'h0000_03EC;
  localparam logic [31:0] H_REL16   = 32'h0000_03ED;
  localparam logic [31:0] H_REL8    = 32'h0000_03EE;
  localparam logic [31:0] H_EXT     = 32'h0000_03EF;
  localparam logic [31:0] H_SYMBOL  = 32'h0000_03F0;
  localparam logic [31:0] H_DEBUG   = 32'h0000_03F1;
  localparam logic [31:0] H_END     = 32'h0000_03F2;
  localparam logic [31:0] H_HEADER  = 32'h0000_03F3;
  localparam logic [31:0] H_OVERLAY = 32'h0000_03F5;
  localparam logic [31:0] H_BREAK   = 32'h0000_03F6;

  // External entry subtypes (high byte)
  localparam logic [7:0] X_SYMB   = 8'd0;
  localparam logic [7:0] X_DEF    = 8'd1;
  localparam logic [7:0] X_ABS    = 8'd2;
  localparam logic [7:0] X_RES    = 8'd3;
  localparam logic [7:0] X_REF32  = 8'd129;
  localparam logic [7:0] X_COMMON = 8'd130;
  localparam logic [7:0] X_REF16  = 8'd131;
  localparam logic [7:0] X_REF8   = 8'd132;

  // Parse phases
  localparam logic [4:0] PH_TYPE       = 5'd0;
  localparam logic [4:0] PH_HDR_LEN    = 5'd1;
  localparam logic [4:0] PH_HDR_NAME   = 5'd2;
  localparam logic [4:0] PH_HDR_TSIZE  = 5'd3;
  localparam logic [4:0] PH_HDR_FIRST  = 5'd4;
  localparam logic [4:0] PH_HDR_LAST   = 5'd5;
  localparam logic [4:0] PH_HDR_SIZES  = 5'd6;
  localparam logic [4:0] PH_BLK_LEN    = 5'd7;
  localparam logic [4:0] PH_BLK_BODY   = 5'd8;
  localparam logic [4:0] PH_BSS_LEN    = 5'd9;
  localparam logic [4:0] PH_REL_COUNT  = 5'd10;
  localparam logic [4:0] PH_REL_HUNK   = 5'd11;
  localparam logic [4:0] PH_REL_OFFS   = 5'd12;
  localparam logic [4:0] PH_EXT_HEAD   = 5'd13;
  localparam logic [4:0] PH_EXT_DNAME  = 5'd14;
  localparam logic [4:0] PH_EXT_DVALUE = 5'd15;
  localparam logic [4:0] PH_EXT_RNAME  = 5'd16;
  localparam logic [4:0] PH_EXT_CNAME  = 5'd17;
  localparam logic [4:0] PH_EXT_CSIZE  = 5'd18;
  localparam logic [4:0] PH_EXT_RCNT   = 5'd19;
  localparam logic [4:0] PH_EXT_REFS   = 5'd20;
  localparam logic [4:0] PH_SYM_LEN    = 5'd21;
  localparam logic [4:0] PH_SYM_NAME   = 5'd22;
  localparam logic [4:0] PH_SYM_VALUE  = 5'd23;
  localparam logic [4:0] PH_DBG_LEN    = 5'd24;
  localparam logic [4:0] PH_DBG_BODY   = 5'd25;
  localparam logic [4:0] PH_HALT       = 5'd26;

  // Status codes
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_BADHUNK = 3'd1;
  localparam logic [2:0] ST_OVERLAY = 3'd2;
  localparam logic [2:0] ST_BADEXT  = 3'd3;
  localparam logic [2:0] ST_NOSYM   = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;
  localparam logic [2:0] ST_TRUNC   = 3'd6;

endpackage

// File: rtl/object_file_symbol_hunk_stripper.sv
// ----------------------------------------------------------------------------
// object_file_symbol_hunk_stripper: drops symbol and debug hunks from objects
// Walks the hunk structure of a hunk-format object file one longword per item
// and marks each word keep or drop; reports completion, missing symbols,
// truncation or format errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): one file longword
//   per item, or an item with end_of_file set to close the file.
//   Output channel (out_valid_o / out_stall_i / out_item_o): exactly one
//   result per input item: the echoed word, its keep flag and a status.
//   Status is 0 while parsing; a nonzero status is latched and every later
//   item returns keep 0 with that status until reset.
//   The result is registered: valid in the cycle after the item is accepted.
//   Throughput: one item per cycle unless stalled; the whole parse step for
//   a word is one phase decode plus a counter decrement (or the header span
//   subtract) between the parser state registers and the result register.
//   When the receiver stalls, the result register holds and the input
//   stalls only while that register is full and stalled; an item is taken
//   in the same cycle the pending result drains.
//   Reset (rst_ni low, asynchronous) returns the parser to expect a hunk
//   type word, clears counters, flags and the error, and empties the output.
// ----------------------------------------------------------------------------
module object_file_symbol_hunk_stripper import hstrip_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctl_t                  ctl_q, ctl_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [31:0]           first_q, first_d;
  out_item_t             res_d, res_q;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;

  // Handshake: take an item whenever the result register can be refilled
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  hstrip_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .ctl_i  (ctl_q),
    .cnt_i  (cnt_q),
    .first_i(first_q),
    .item_i (in_item_i),
    .ctl_o  (ctl_d),
    .cnt_o  (cnt_d),
    .first_o(first_d),
    .res_o  (res_d)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= '{phase: PH_TYPE, seen: 1'b0, err: ST_RUN};
      cnt_q   <= '0;
      first_q <= '0;
    end else if (accept) begin
      ctl_q   <= ctl_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  // Checks
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.phase == PH_HALT) |=> (ctl_q.phase == PH_HALT))
    else $error("parser left halt state");

  a_keep_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.keep) |-> (out_item_o.status == ST_RUN))
    else $error("kept word carries a nonzero status");

  a_body_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.phase == PH_BLK_BODY || ctl_q.phase == PH_SYM_NAME ||
     ctl_q.phase == PH_REL_OFFS) |-> (cnt_q != '0))
    else $error("body phase entered with zero count");

endmodule

// File: rtl/hstrip_step.sv
// ----------------------------------------------------------------------------
// hstrip_step: one parse step of the hunk walker
// Given the current parser state and one item, computes the next state and
// the result item (keep decision and status).
// ----------------------------------------------------------------------------
module hstrip_step import hstrip_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  ctl_t                  ctl_i,
  input  logic [COUNT_BITS-1:0] cnt_i,
  input  logic [31:0]           first_i,
  input  in_item_t              item_i,
  output ctl_t                  ctl_o,
  output logic [COUNT_BITS-1:0] cnt_o,
  output logic [31:0]           first_o,
  output out_item_t             res_o
);

  logic [31:0]           w;
  logic                  eof;
  logic                  halted;
  logic                  keep;
  logic [COUNT_BITS-1:0] wlen;
  logic                  wlen_nz;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic                  cnt_last;
  logic [31:0]           span;
  logic [COUNT_BITS-1:0] span_len;
  logic [31:0]           ext_len32;
  logic [COUNT_BITS-1:0] ext_len;
  logic [7:0]            ext_sub;

  assign w        = item_i.word;
  assign eof      = item_i.end_of_file;
  assign halted   = (ctl_i.phase == PH_HALT);

  // Length words cut to the counter width
  assign wlen      = w[COUNT_BITS-1:0];
  assign wlen_nz   = |wlen;
  assign cnt_dec   = cnt_i - COUNT_BITS'(1);
  assign cnt_last  = (cnt_dec == '0);
  assign span      = w - first_i + 32'd1;
  assign span_len  = span[COUNT_BITS-1:0];
  assign ext_len32 = {8'h00, w[23:0]};
  assign ext_len   = ext_len32[COUNT_BITS-1:0];
  assign ext_sub   = w[31:24];

  // Next-state decode
  always_comb begin
    ctl_o   = ctl_i;
    cnt_o   = cnt_i;
    first_o = first_i;
    keep    = 1'b1;
    if (!halted && eof) begin
      ctl_o.phase = PH_HALT;
      if (ctl_i.phase != PH_TYPE) ctl_o.err = ST_TRUNC;
      else                        ctl_o.err = ctl_i.seen ? ST_DONE : ST_NOSYM;
    end else if (!halted) begin
      unique case (ctl_i.phase)
        PH_TYPE: begin
          unique case (w)
            H_HEADER: ctl_o.phase = PH_HDR_LEN;
            H_UNIT, H_NAME, H_CODE, H_DATA: ctl_o.phase = PH_BLK_LEN;
            H_BSS: ctl_o.phase = PH_BSS_LEN;
            H_REL32, H_REL16, H_REL8: ctl_o.phase = PH_REL_COUNT;
            H_EXT: ctl_o.phase = PH_EXT_HEAD;
            H_END: ctl_o.phase = PH_TYPE;
            H_SYMBOL: begin
              keep        = 1'b0;
              ctl_o.seen  = 1'b1;
              ctl_o.phase = PH_SYM_LEN;
            end
            H_DEBUG: begin
              keep        = 1'b0;
              ctl_o.phase = PH_DBG_LEN;
            end
            H_OVERLAY, H_BREAK: begin
              ctl_o.phase = PH_HALT;
              ctl_o.err   = ST_OVERLAY;
            end
            default: begin
              ctl_o.phase = PH_HALT;
              ctl_o.err   = ST_BADHUNK;
            end
          endcase
        end
        // Header hunk: name list, table size, first/last, size table
        PH_HDR_LEN: begin
          if (w == 32'd0) begin
            ctl_o.phase = PH_HDR_TSIZE;
          end else begin
            cnt_o       = wlen;
            ctl_o.phase = wlen_nz ? PH_HDR_NAME : PH_HDR_LEN;
          end
        end
        PH_HDR_NAME: begin
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_HDR_LEN;
        end
        PH_HDR_TSIZE: ctl_o.phase = PH_HDR_FIRST;
        PH_HDR_FIRST: begin
          first_o     = w;
          ctl_o.phase = PH_HDR_LAST;
        end
        PH_HDR_LAST: begin
          cnt_o       = span_len;
          ctl_o.phase = (|span_len) ? PH_HDR_SIZES : PH_TYPE;
        end
        PH_HDR_SIZES: begin
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_TYPE;
        end
        // Plain length-prefixed blocks
        PH_BLK_LEN: begin
          cnt_o       = wlen;
          ctl_o.phase = wlen_nz ? PH_BLK_BODY : PH_TYPE;
        end
        PH_BLK_BODY: begin
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_TYPE;
        end
        PH_BSS_LEN: ctl_o.phase = PH_TYPE;
        // Relocation groups: count, target hunk, offsets
        PH_REL_COUNT: begin
          if (w == 32'd0) begin
            ctl_o.phase = PH_TYPE;
          end else begin
            cnt_o       = wlen;
            ctl_o.phase = PH_REL_HUNK;
          end
        end
        PH_REL_HUNK: ctl_o.phase = (|cnt_i) ? PH_REL_OFFS : PH_REL_COUNT;
        PH_REL_OFFS: begin
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_REL_COUNT;
        end
        // External entries
        PH_EXT_HEAD: begin
          if (w == 32'd0) begin
            ctl_o.phase = PH_TYPE;
          end else begin
            unique case (ext_sub)
              X_SYMB, X_DEF, X_ABS, X_RES: begin
                cnt_o       = ext_len;
                ctl_o.phase = (|ext_len) ? PH_EXT_DNAME : PH_EXT_DVALUE;
              end
              X_REF32, X_REF16, X_REF8: begin
                cnt_o       = ext_len;
                ctl_o.phase = (|ext_len) ? PH_EXT_RNAME : PH_EXT_RCNT;
              end
              X_COMMON: begin
                cnt_o       = ext_len;
                ctl_o.phase = (|ext_len) ? PH_EXT_CNAME : PH_EXT_CSIZE;
              end
              default: begin
                ctl_o.phase = PH_HALT;
                ctl_o.err   = ST_BADEXT;
              end
            endcase
          end
        end
        PH_EXT_DNAME: begin
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_EXT_DVALUE;
        end
        PH_EXT_DVALUE: ctl_o.phase = PH_EXT_HEAD;
        PH_EXT_RNAME: begin
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_EXT_RCNT;
        end
        PH_EXT_CNAME: begin
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_EXT_CSIZE;
        end
        PH_EXT_CSIZE: ctl_o.phase = PH_EXT_RCNT;
        PH_EXT_RCNT: begin
          cnt_o       = wlen;
          ctl_o.phase = wlen_nz ? PH_EXT_REFS : PH_EXT_HEAD;
        end
        PH_EXT_REFS: begin
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_EXT_HEAD;
        end
        // Symbol hunk: dropped
        PH_SYM_LEN: begin
          keep = 1'b0;
          if (w == 32'd0) begin
            ctl_o.phase = PH_TYPE;
          end else begin
            cnt_o       = wlen;
            ctl_o.phase = wlen_nz ? PH_SYM_NAME : PH_SYM_VALUE;
          end
        end
        PH_SYM_NAME: begin
          keep  = 1'b0;
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_SYM_VALUE;
        end
        PH_SYM_VALUE: begin
          keep        = 1'b0;
          ctl_o.phase = PH_SYM_LEN;
        end
        // Debug hunk: dropped
        PH_DBG_LEN: begin
          keep        = 1'b0;
          cnt_o       = wlen;
          ctl_o.phase = wlen_nz ? PH_DBG_BODY : PH_TYPE;
        end
        PH_DBG_BODY: begin
          keep  = 1'b0;
          cnt_o = cnt_dec;
          if (cnt_last) ctl_o.phase = PH_TYPE;
        end
        default: begin
          ctl_o.phase = PH_HALT;
          ctl_o.err   = ST_BADHUNK;
        end
      endcase
    end
  end

  // Result item
  always_comb begin
    res_o.out_word = eof ? 32'd0 : w;
    res_o.keep     = (ctl_o.phase == PH_HALT) ? 1'b0 : keep;
    res_o.status   = (ctl_o.phase == PH_HALT) ? ctl_o.err : ST_RUN;
  end

endmodule
